[rtl/bmpd_pkg.sv]
`timescale 1ns / 1ps

package bmpd_pkg;

   typedef enum logic [1:0] {
      ACT_MEM_ACCESS = 2'd0,
      ACT_PORT_READ  = 2'd1,
      ACT_PORT_WRITE = 2'd2,
      ACT_TICK       = 2'd3
   } action_type;

   localparam int unsigned FRAME_WIDTH = 17;
   localparam int unsigned KEY_ROWS    = 8;
   localparam int unsigned KEY_COLS    = 5;

   localparam logic [FRAME_WIDTH-1:0] FRAME_LENGTH_RESET = 17'd70908;

   localparam logic [1:0] SLOT_ROM    = 2'd0;
   localparam logic [1:0] SLOT_LOW    = 2'd1;
   localparam logic [1:0] SLOT_MID    = 2'd2;
   localparam logic [2:0] BANK_SLOT_1 = 3'd5;
   localparam logic [2:0] BANK_SLOT_2 = 3'd2;

   localparam logic [1:0] SND_SELECT_CODE = 2'b11;
   localparam logic [1:0] SND_WRITE_CODE  = 2'b10;
   localparam logic [7:0] KNOB_PORT       = 8'h5F;
   localparam logic [7:0] READ_IDLE       = 8'hFF;

   typedef struct packed {
      action_type               action;
      logic [15:0]              address;
      logic [7:0]               write_data;
      logic [KEY_ROWS*KEY_COLS-1:0] key_rows;
      logic                     ear_in;
      logic [7:0]               joystick;
      logic [7:0]               knob_value;
      logic [7:0]               sound_read_data;
      logic [7:0]               tstates;
   } req_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic        mem_is_rom;
      logic [2:0]  mem_bank;
      logic [13:0] mem_offset;
      logic        mem_writable;
      logic [2:0]  border_colour;
      logic        mic_out;
      logic        beeper_out;
      logic        shadow_screen;
      logic [3:0]  sound_register;
      logic        sound_write;
      logic        frame_interrupt;
   } rsp_type;

endpackage

[rtl/bmpd_read_mux.sv]
`timescale 1ns / 1ps

module bmpd_read_mux
   import bmpd_pkg::*;
(
   input  req_type    req,
   output logic [7:0] read_data
);

   logic [KEY_COLS-1:0] keys;

   always_comb begin
      keys = '1;
      for (int r = 0; r < KEY_ROWS; r++) begin
         if (!req.address[8 + r]) begin
            keys = keys & req.key_rows[KEY_COLS*r +: KEY_COLS];
         end
      end
   end

   always_comb begin
      if (!req.address[0]) begin
         read_data = {1'b1, req.ear_in, 1'b1, keys};
      end else if (req.address[15:14] == SND_SELECT_CODE) begin
         read_data = req.sound_read_data;
      end else if (req.address[7:0] == KNOB_PORT) begin
         read_data = req.knob_value;
      end else if (!req.address[5]) begin
         read_data = req.joystick;
      end else begin
         read_data = READ_IDLE;
      end
   end

endmodule

[rtl/bmpd_core.sv]
`timescale 1ns / 1ps

module bmpd_core
   import bmpd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  req_type                req,
   input  logic                   csr_write_en,
   input  logic [FRAME_WIDTH-1:0] csr_write_data,
   output rsp_type                result
);

   logic [FRAME_WIDTH-1:0] frame_length_ff;
   logic [5:0]             paging_latch_ff, paging_latch_in;
   logic                   paging_locked_ff, paging_locked_in;
   logic [2:0]             border_ff, border_in;
   logic                   mic_ff, mic_in;
   logic                   beeper_ff, beeper_in;
   logic [3:0]             sound_select_ff, sound_select_in;
   logic [FRAME_WIDTH-1:0] frame_count_ff, frame_count_in;

   logic [7:0]           port_data;
   logic [FRAME_WIDTH:0] sum;
   logic [FRAME_WIDTH:0] diff;
   logic                 wrap;

   bmpd_read_mux u_read_mux (
      .req       (req),
      .read_data (port_data)
   );

   assign sum  = {1'b0, frame_count_ff} + {{(FRAME_WIDTH - 7){1'b0}}, req.tstates};
   assign diff = sum - {1'b0, frame_length_ff};
   assign wrap = (sum >= {1'b0, frame_length_ff});

   always_comb begin
      paging_latch_in  = paging_latch_ff;
      paging_locked_in = paging_locked_ff;
      border_in        = border_ff;
      mic_in           = mic_ff;
      beeper_in        = beeper_ff;
      sound_select_in  = sound_select_ff;
      frame_count_in   = frame_count_ff;
      result           = '0;

      unique case (req.action)
         ACT_MEM_ACCESS: begin
            result.mem_offset = req.address[13:0];
            case (req.address[15:14])
               SLOT_ROM: begin
                  result.mem_is_rom = 1'b1;
                  result.mem_bank   = {2'b00, paging_latch_ff[4]};
               end
               SLOT_LOW: begin
                  result.mem_writable = 1'b1;
                  result.mem_bank     = BANK_SLOT_1;
               end
               SLOT_MID: begin
                  result.mem_writable = 1'b1;
                  result.mem_bank     = BANK_SLOT_2;
               end
               default: begin
                  result.mem_writable = 1'b1;
                  result.mem_bank     = paging_latch_ff[2:0];
               end
            endcase
         end
         ACT_PORT_READ: begin
            result.read_data = port_data;
         end
         ACT_PORT_WRITE: begin
            if (!req.address[0]) begin
               border_in = req.write_data[2:0];
               mic_in    = req.write_data[3];
               beeper_in = req.write_data[4];
            end
            if (!req.address[15] && !req.address[1] && !paging_locked_ff) begin
               paging_latch_in  = req.write_data[5:0];
               paging_locked_in = req.write_data[5];
            end
            if (req.address[15:14] == SND_SELECT_CODE) begin
               sound_select_in = req.write_data[3:0];
            end else if (req.address[15:14] == SND_WRITE_CODE) begin
               result.sound_write = 1'b1;
            end
         end
         ACT_TICK: begin
            result.frame_interrupt = wrap;
            frame_count_in = wrap ? diff[FRAME_WIDTH-1:0] : sum[FRAME_WIDTH-1:0];
         end
         default: begin
         end
      endcase

      result.border_colour  = border_in;
      result.mic_out        = mic_in;
      result.beeper_out     = beeper_in;
      result.shadow_screen  = paging_latch_in[3];
      result.sound_register = sound_select_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_length_ff  <= FRAME_LENGTH_RESET;
         paging_latch_ff  <= '0;
         paging_locked_ff <= 1'b0;
         border_ff        <= '0;
         mic_ff           <= 1'b0;
         beeper_ff        <= 1'b0;
         sound_select_ff  <= '0;
         frame_count_ff   <= '0;
      end else begin
         if (csr_write_en) begin
            frame_length_ff <= csr_write_data;
         end
         if (advance) begin
            paging_latch_ff  <= paging_latch_in;
            paging_locked_ff <= paging_locked_in;
            border_ff        <= border_in;
            mic_ff           <= mic_in;
            beeper_ff        <= beeper_in;
            sound_select_ff  <= sound_select_in;
            frame_count_ff   <= frame_count_in;
         end
      end
   end

endmodule

[rtl/banked_memory_and_port_decoder_top.sv]
`timescale 1ns / 1ps
// Banked memory mapper and I/O port decoder for a 128K home computer bus.
// Request channel (req_valid / req_stall / req_payload): one transaction per
// memory access, port read, port write or frame tick, chosen by action.
// Response channel (rsp_valid / rsp_stall / rsp_payload): exactly one
// transaction per request, in order: bank mapping, port read data, current
// border/MIC/beeper, shadow screen, sound register select and the sound
// write and frame interrupt pulses.
// A taken request is held in the input register, then decoded and applied to
// the paging/port/frame state as its response enters the response register.
// Throughput is one transaction per cycle while rsp_stall is low, set by the
// single decode stage between the input and response registers.
// csr_write_en / csr_write_data load the frame length in T-states; write it
// only while no transaction is in flight.
// Reset (synchronous) empties both registers, clears the paging latch and
// its lock, border, MIC, beeper, sound select and frame counter, and sets
// the frame length to 70908. While rsp_stall is high the response holds;
// one more request is taken into the input register, then req_stall rises.

module banked_memory_and_port_decoder_top
   import bmpd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_payload,
   input  logic                   csr_write_en,
   input  logic [FRAME_WIDTH-1:0] csr_write_data
);

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;
   rsp_type result;
   logic    out_free;
   logic    advance;
   logic    accept;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   bmpd_core u_core (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .req            (in_data_ff),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .result         (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_payload;
      end
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

[rtl/bmpd_checker.sv]
`timescale 1ns / 1ps

module bmpd_checker
   import bmpd_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_payload
);

   // response held while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // port read data and a memory mapping never share one transaction
   a_read_no_map: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.read_data != 8'h00 |->
         !rsp_payload.mem_is_rom && !rsp_payload.mem_writable &&
         rsp_payload.mem_offset == 14'd0)
      else $error("read data alongside memory mapping");

   a_rom_readonly: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.mem_is_rom |->
         !rsp_payload.mem_writable && rsp_payload.mem_bank[2:1] == 2'b00)
      else $error("ROM slot writable or bad ROM number");

   a_pulse_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_payload.sound_write && rsp_payload.frame_interrupt))
      else $error("sound write and frame interrupt in one transaction");

endmodule

bind banked_memory_and_port_decoder_top bmpd_checker u_checker (.*);
